// File: rtl/curvature_lookahead_speed_ref_defines.svh
// Assertion macros for the curvature look-ahead speed reference block.
`ifndef CURVATURE_LOOKAHEAD_SPEED_REF_DEFINES_SVH
`define CURVATURE_LOOKAHEAD_SPEED_REF_DEFINES_SVH
`ifndef SYNTH
// clocked check, off while reset is high
`define CLS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// clocked check, active also during reset
`define CLS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define CLS_ASSERT(lbl, prop, msg)
`define CLS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/cls_pkg.sv
// Shared types, constants and tables of the curvature look-ahead speed block.
`default_nettype none
package cls_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam logic [15:0] WHEELBASE_RESET = 16'd11469;
   localparam int LN2_Q30 = 744261118;
   localparam logic [15:0] SPEED_MAX = 16'd40960;
   localparam logic [15:0] SPEED_OFFSET = 16'd12288;
   localparam logic [21:0] SQRT_BIAS = 22'd8192;
   // ceil(2^23 / 10), exact quotient for values below 2^19
   localparam logic [19:0] DIV10_MUL = 20'd838861;
   localparam int DIV10_SHIFT = 23;
   localparam logic [3:0] HORNER_DEG = 4'd9;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_MUL    = 14'b00000000000010,
      ST_CORDIC = 14'b00000000000100,
      ST_TPREP  = 14'b00000000001000,
      ST_REDUCE = 14'b00000000010000,
      ST_HMUL   = 14'b00000000100000,
      ST_HREC   = 14'b00000001000000,
      ST_HQJ    = 14'b00000010000000,
      ST_HFIX   = 14'b00000100000000,
      ST_EXPO   = 14'b00001000000000,
      ST_SQRT   = 14'b00010000000000,
      ST_MIN    = 14'b00100000000000,
      ST_SMUL   = 14'b01000000000000,
      ST_DONE   = 14'b10000000000000
   } state_type;

   // atan(2^-i) in Q30; 2^(30-i) past the table
   function automatic logic [30:0] atan_step(input logic [5:0] idx);
      logic [30:0] val;
      begin
         val = '0;
         if (idx < 6'd10) begin
            unique case (idx)
               6'd0: val = 31'd843314857;
               6'd1: val = 31'd497837829;
               6'd2: val = 31'd263043837;
               6'd3: val = 31'd133525159;
               6'd4: val = 31'd67021687;
               6'd5: val = 31'd33543516;
               6'd6: val = 31'd16775851;
               6'd7: val = 31'd8388437;
               6'd8: val = 31'd4194283;
               6'd9: val = 31'd2097149;
               default: val = '0;
            endcase
         end else if (idx <= 6'd30) begin
            val = (31'd1 << 30) >> idx;
         end
         return val;
      end
   endfunction

   // floor(2^32 / j) for the Horner divisors
   function automatic logic [32:0] recip_j(input logic [3:0] j);
      logic [32:0] val;
      begin
         unique case (j)
            4'd1: val = 33'd4294967296;
            4'd2: val = 33'd2147483648;
            4'd3: val = 33'd1431655765;
            4'd4: val = 33'd1073741824;
            4'd5: val = 33'd858993459;
            4'd6: val = 33'd715827882;
            4'd7: val = 33'd613566756;
            4'd8: val = 33'd536870912;
            4'd9: val = 33'd477218588;
            default: val = '0;
         endcase
         return val;
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/cls_if.sv
// Handshake channel interfaces: request, response and register write.
`default_nettype none
interface cls_req_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] path_curvature;
   logic signed [23:0] lookahead_dist;
   modport source (output valid, path_curvature, lookahead_dist, input ready);
   modport sink (input valid, path_curvature, lookahead_dist, output ready);
endinterface

interface cls_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] ref_speed;
   modport source (output valid, ref_speed, input ready);
   modport sink (input valid, ref_speed, output ready);
endinterface

interface cls_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] wheelbase_length;
   modport source (output valid, wheelbase_length, input ready);
   modport sink (input valid, wheelbase_length, output ready);
endinterface
`default_nettype wire

// File: rtl/curvature_lookahead_speed_ref.sv
// Top level: speed reference from path curvature and look-ahead distance.
//
//   channel  dir  payload                          width
//   req_ch   in   path_curvature, lookahead_dist   20s, 24s
//   rsp_ch   out  ref_speed                        16u
//   csr_ch   in   wheelbase_length                 16u
//
// One item runs through the sequencer in this order, from the accept onward:
// 16 CORDIC steps, range reduction (at most 23 steps), HMUL, HREC, HQJ and HFIX
// for each Horner term (9 terms) on the one shared multiplier, 22 square-root steps,
// and a divide state that a zero result skips.
// req_ch is ready only while idle; a finished result waits in the rsp_ch
// register, and a new item is taken while it waits. Reset is synchronous.
`default_nettype none
`include "curvature_lookahead_speed_ref_defines.svh"
module curvature_lookahead_speed_ref (
   input wire logic   clock,
   input wire logic   reset,
   cls_req_if.sink    req_ch,
   cls_rsp_if.source  rsp_ch,
   cls_csr_if.sink    csr_ch
);

   cls_pkg::state_type state_ff, state_in;

   logic [15:0]        wb_ff, wb_in;
   logic [15:0]        prev_ff, prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   logic [19:0]        absk_ff, absk_in;
   logic signed [23:0] dist_ff, dist_in;
   logic signed [39:0] x_ff, x_in;
   logic signed [39:0] y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [5:0]         iter_ff, iter_in;
   logic signed [36:0] r_ff, r_in;
   logic signed [5:0]  n_ff, n_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        xh_ff, xh_in;
   logic [32:0]        q0_ff, q0_in;
   logic [3:0]         j_ff, j_in;
   logic [15:0]        sc_ff, sc_in;
   logic [42:0]        v_ff, v_in;
   logic [42:0]        res_ff, res_in;
   logic [42:0]        bit_ff, bit_in;
   logic [15:0]        spd_ff, spd_in;
   logic [65:0]        mul_ff;

   // shared multiplier
   logic [32:0]        mul_a, mul_b;
   logic [65:0]        mul_p;

   logic [19:0]        k_abs;
   logic [42:0]        d_ext;
   logic [31:0]        angle;
   logic [36:0]        ten_a;
   logic signed [36:0] ln2;
   logic [36:0]        rem;
   logic [32:0]        q_fix;
   logic [5:0]         exp_sh;
   logic [47:0]        exp_val;
   logic [47:0]        sc_full;
   logic [42:0]        sq_sum;
   logic [21:0]        sd_raw;
   logic [15:0]        sd;
   logic [15:0]        sp;
   logic [18:0]        smix;
   logic               rsp_free;

   assign req_ch.ready = (state_ff == cls_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.ref_speed = rsp_data_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign ln2 = 37'(cls_pkg::LN2_Q30);

   assign mul_p = 66'(mul_a) * 66'(mul_b);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         cls_pkg::ST_MUL: begin
            mul_a = {13'd0, absk_ff};
            mul_b = {17'd0, wb_ff};
         end
         cls_pkg::ST_HMUL: begin
            mul_a = {1'b0, acc_ff};
            mul_b = {3'd0, r_ff[29:0]};
         end
         cls_pkg::ST_HREC: begin
            mul_a = {1'b0, mul_ff[61:30]};
            mul_b = cls_pkg::recip_j(j_ff);
         end
         cls_pkg::ST_HQJ: begin
            mul_a = mul_ff[64:32];
            mul_b = {29'd0, j_ff};
         end
         cls_pkg::ST_MIN: begin
            mul_a = {14'd0, smix};
            mul_b = {13'd0, cls_pkg::DIV10_MUL};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      k_abs = req_ch.path_curvature[19] ? 20'(-req_ch.path_curvature)
                                        : 20'(req_ch.path_curvature);
      // 5 * d * 65536
      d_ext = {20'd0, req_ch.lookahead_dist[22:0]};
      angle = z_ff[32] ? 32'd0 : z_ff[31:0];
      ten_a = ({5'd0, angle} << 3) + ({5'd0, angle} << 1);
      rem = {5'd0, xh_ff} - mul_ff[36:0];
      q_fix = q0_ff + ((rem >= {33'd0, j_ff}) ? 33'd1 : 33'd0);
      exp_sh = 6'd18 - $unsigned(n_ff);
      exp_val = ({16'd0, acc_ff} + (48'd1 << (exp_sh - 6'd1))) >> exp_sh;
      sc_full = exp_val + {32'd0, cls_pkg::SPEED_OFFSET};
      sq_sum = res_ff + bit_ff;
      sd_raw = (res_ff[21:0] > cls_pkg::SQRT_BIAS) ? res_ff[21:0] - cls_pkg::SQRT_BIAS
                                                   : 22'd0;
      if (dist_ff <= 24'sd0) begin
         sd = '0;
      end else if (sd_raw > {6'd0, cls_pkg::SPEED_MAX}) begin
         sd = cls_pkg::SPEED_MAX;
      end else begin
         sd = sd_raw[15:0];
      end
      sp = (sc_ff < sd) ? sc_ff : sd;
      smix = 19'(prev_ff) * 19'd7 + 19'(sp) * 19'd3 + 19'd5;
   end

   always_comb begin
      state_in = state_ff;
      wb_in = csr_ch.valid ? csr_ch.wheelbase_length : wb_ff;
      prev_in = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in = rsp_data_ff;
      absk_in = absk_ff;
      dist_in = dist_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      iter_in = iter_ff;
      r_in = r_ff;
      n_in = n_ff;
      acc_in = acc_ff;
      xh_in = xh_ff;
      q0_in = q0_ff;
      j_in = j_ff;
      sc_in = sc_ff;
      v_in = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      spd_in = spd_ff;
      unique case (state_ff)
         cls_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               absk_in = k_abs;
               dist_in = req_ch.lookahead_dist;
               v_in = (req_ch.lookahead_dist > 24'sd0) ? (d_ext << 18) + (d_ext << 16)
                                                       : 43'd0;
               res_in = '0;
               bit_in = 43'd1 << 42;
               state_in = cls_pkg::ST_MUL;
            end
         end
         cls_pkg::ST_MUL: begin
            x_in = 40'sd1 <<< 28;
            y_in = $signed({4'd0, mul_p[35:0]});
            z_in = '0;
            iter_in = '0;
            state_in = cls_pkg::ST_CORDIC;
         end
         cls_pkg::ST_CORDIC: begin
            if (!y_ff[39]) begin
               x_in = x_ff + (y_ff >>> iter_ff);
               y_in = y_ff - (x_ff >>> iter_ff);
               z_in = z_ff + $signed({2'd0, cls_pkg::atan_step(iter_ff)});
            end else begin
               x_in = x_ff - (y_ff >>> iter_ff);
               y_in = y_ff + (x_ff >>> iter_ff);
               z_in = z_ff - $signed({2'd0, cls_pkg::atan_step(iter_ff)});
            end
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'(cls_pkg::CORDIC_STEPS - 1)) begin
               state_in = cls_pkg::ST_TPREP;
            end
         end
         cls_pkg::ST_TPREP: begin
            // t = 2.0 - 10 * angle
            r_in = $signed(37'h0_8000_0000 - ten_a);
            n_in = '0;
            state_in = cls_pkg::ST_REDUCE;
         end
         cls_pkg::ST_REDUCE: begin
            priority if (r_ff < 37'sd0) begin
               r_in = r_ff + ln2;
               n_in = n_ff - 6'sd1;
            end else if (r_ff >= ln2) begin
               r_in = r_ff - ln2;
               n_in = n_ff + 6'sd1;
            end else begin
               acc_in = 32'd1 << 30;
               j_in = cls_pkg::HORNER_DEG;
               state_in = cls_pkg::ST_HMUL;
            end
         end
         cls_pkg::ST_HMUL: begin
            state_in = cls_pkg::ST_HREC;
         end
         cls_pkg::ST_HREC: begin
            xh_in = mul_ff[61:30];
            state_in = cls_pkg::ST_HQJ;
         end
         cls_pkg::ST_HQJ: begin
            q0_in = mul_ff[64:32];
            state_in = cls_pkg::ST_HFIX;
         end
         cls_pkg::ST_HFIX: begin
            // quotient estimate is low by at most one
            acc_in = (32'd1 << 30) + q_fix[31:0];
            j_in = j_ff - 4'd1;
            state_in = (j_ff == 4'd1) ? cls_pkg::ST_EXPO : cls_pkg::ST_HMUL;
         end
         cls_pkg::ST_EXPO: begin
            sc_in = (sc_full > {32'd0, cls_pkg::SPEED_MAX}) ? cls_pkg::SPEED_MAX
                                                            : sc_full[15:0];
            state_in = cls_pkg::ST_SQRT;
         end
         cls_pkg::ST_SQRT: begin
            if (v_ff >= sq_sum) begin
               v_in = v_ff - sq_sum;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = cls_pkg::ST_MIN;
            end
         end
         cls_pkg::ST_MIN: begin
            if (sp == 16'd0) begin
               spd_in = '0;
               state_in = cls_pkg::ST_DONE;
            end else begin
               state_in = cls_pkg::ST_SMUL;
            end
         end
         cls_pkg::ST_SMUL: begin
            spd_in = mul_ff[cls_pkg::DIV10_SHIFT +: 16];
            state_in = cls_pkg::ST_DONE;
         end
         cls_pkg::ST_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = spd_ff;
               prev_in = spd_ff;
               state_in = cls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cls_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cls_pkg::ST_IDLE;
         wb_ff <= cls_pkg::WHEELBASE_RESET;
         prev_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wb_ff <= wb_in;
         prev_ff <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      absk_ff <= absk_in;
      dist_ff <= dist_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      iter_ff <= iter_in;
      r_ff <= r_in;
      n_ff <= n_in;
      acc_ff <= acc_in;
      xh_ff <= xh_in;
      q0_ff <= q0_in;
      j_ff <= j_in;
      sc_ff <= sc_in;
      v_ff <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      spd_ff <= spd_in;
      mul_ff <= mul_p;
   end

   `CLS_ASSERT(a_accept_starts, (req_ch.valid && req_ch.ready) |=> (state_ff == cls_pkg::ST_MUL), "accepted item did not start the sequencer")
   `CLS_ASSERT(a_speed_range, rsp_valid_ff |-> (rsp_data_ff <= cls_pkg::SPEED_MAX), "speed above limit")
   `CLS_ASSERT(a_prev_matches, rsp_valid_ff |-> (prev_ff == rsp_data_ff), "stored speed differs from output")
   `CLS_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == cls_pkg::ST_IDLE && !rsp_valid_ff), "reset did not clear control")

endmodule
`default_nettype wire
